/* src/plmm_pkg.sv */
// ---------------------------------------------------------------------------
// Packed low-bit matrix multiply package
// Shared widths, codes, control structs and the packed word product.
// ---------------------------------------------------------------------------
package plmm_pkg;

    // Default sizes of the word stores and the accumulator
    localparam int MaxRowsDefault  = 64;
    localparam int MaxInnerDefault = 64;
    localparam int MaxColsDefault  = 64;
    localparam int AccBitsDefault  = 32;

    // Fixed field widths
    localparam int WORD_BITS     = 8;
    localparam int KIND_BITS     = 2;
    localparam int IDX_BITS      = 6;
    localparam int MODE_BITS     = 2;
    localparam int LEN_BITS      = 7;
    localparam int SUM_BITS      = 32;
    localparam int PROD_BITS     = 16;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 7;
    localparam int CMP_BITS      = 11;

    // Input item kinds
    typedef enum logic [KIND_BITS-1:0] {
        KIND_WR_A    = 2'd0,
        KIND_WR_B    = 2'd1,
        KIND_COMPUTE = 2'd2
    } t_kind;

    // Lane formats
    typedef enum logic [MODE_BITS-1:0] {
        MODE_BYTE = 2'd0,
        MODE_TERN = 2'd1,
        MODE_QUAD = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MODE      = 1'd0,
        CFG_INNER_LEN = 1'd1
    } t_cfg_idx;

    // Command from the front end to the engine
    typedef struct packed {
        logic                  wr_a;
        logic                  wr_b;
        logic                  start;
        logic [IDX_BITS-1:0]   row;
        logic [IDX_BITS-1:0]   col;
        logic [WORD_BITS-1:0]  word;
        logic [MODE_BITS-1:0]  mode;
        logic [LEN_BITS-1:0]   len;
    } t_eng_cmd;

    // Status and result from the engine
    typedef struct packed {
        logic                       busy;
        logic                       valid;
        logic signed [SUM_BITS-1:0] sum;
    } t_eng_rsp;

    // Sum of lane products of one A word and one B word
    function automatic logic signed [PROD_BITS-1:0] word_product(
        input logic [WORD_BITS-1:0] aw,
        input logic [WORD_BITS-1:0] bw,
        input logic [MODE_BITS-1:0] md
    );
        logic signed [PROD_BITS-1:0] acc;
        logic signed [7:0]           ba;
        logic signed [7:0]           bb;
        logic signed [3:0]           qa;
        logic signed [3:0]           qb;
        logic signed [1:0]           ta;
        logic signed [1:0]           tb;
        int                          j;
        acc = '0;
        ba  = aw;
        bb  = bw;
        case (md)
            MODE_BYTE: begin
                acc = PROD_BITS'(ba) * PROD_BITS'(bb);
            end
            MODE_TERN: begin
                // A code +1 adds the B lane, -1 subtracts it, others add nothing
                for (j = 0; j < WORD_BITS / 2; j++) begin
                    ta = aw[2*j +: 2];
                    tb = bw[2*j +: 2];
                    if (ta == 2'sb01) begin
                        acc = acc + PROD_BITS'(tb);
                    end else if (ta == 2'sb11) begin
                        acc = acc - PROD_BITS'(tb);
                    end
                end
            end
            default: begin
                // Quad mode, also taken for the unused code
                for (j = 0; j < WORD_BITS / 4; j++) begin
                    qa  = aw[4*j +: 4];
                    qb  = bw[4*j +: 4];
                    acc = acc + PROD_BITS'(qa) * PROD_BITS'(qb);
                end
            end
        endcase
        return acc;
    endfunction

endpackage

/* src/plmm_if.sv */
// ---------------------------------------------------------------------------
// Packed low-bit matrix multiply channels
// Valid/ready channels for input items, result items and register writes.
// ---------------------------------------------------------------------------
interface plmm_in_if;
    import plmm_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [IDX_BITS-1:0]  row;
    logic [IDX_BITS-1:0]  col;
    logic [WORD_BITS-1:0] word;
    modport source (output valid, kind, row, col, word, input ready);
    modport sink   (input valid, kind, row, col, word, output ready);
endinterface

interface plmm_out_if;
    import plmm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SUM_BITS-1:0] sum;
    modport source (output valid, sum, input ready);
    modport sink   (input valid, sum, output ready);
endinterface

interface plmm_cfg_if;
    import plmm_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/plmm_engine.sv */
// ---------------------------------------------------------------------------
// Packed low-bit matrix multiply engine
// Holds the A and B word stores and walks the inner dimension through one
// shared word product unit, one word pair per cycle.
// ---------------------------------------------------------------------------
module plmm_engine #(
    parameter int MAX_ROWS  = plmm_pkg::MaxRowsDefault,
    parameter int MAX_INNER = plmm_pkg::MaxInnerDefault,
    parameter int MAX_COLS  = plmm_pkg::MaxColsDefault,
    parameter int ACC_BITS  = plmm_pkg::AccBitsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  plmm_pkg::t_eng_cmd i_cmd,
    input  logic               i_take,
    output plmm_pkg::t_eng_rsp o_rsp
);
    import plmm_pkg::*;

    localparam int A_DEPTH  = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH  = MAX_INNER * MAX_COLS;
    localparam int AW       = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int BW       = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
    localparam int CW       = $clog2(MAX_INNER + 1);
    localparam int EXT_BITS = (ACC_BITS > SUM_BITS) ? ACC_BITS : SUM_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    logic [WORD_BITS-1:0] r_mem_a [A_DEPTH];
    logic [WORD_BITS-1:0] r_mem_b [B_DEPTH];

    t_state                      r_state, n_state;
    logic [AW-1:0]               r_a_addr, n_a_addr;
    logic [BW-1:0]               r_b_addr, n_b_addr;
    logic [CW-1:0]               r_left, n_left;
    logic                        r_zero, n_zero;
    logic                        r_v1, n_v1;
    logic                        r_v2;
    logic [WORD_BITS-1:0]        r_a_q;
    logic [WORD_BITS-1:0]        r_b_q;
    logic signed [PROD_BITS-1:0] r_prod;
    logic signed [ACC_BITS-1:0]  r_acc, n_acc;

    logic                        row_ok_a;
    logic                        col_ok_a;
    logic                        row_ok_b;
    logic                        col_ok_b;
    logic [AW-1:0]               a_waddr;
    logic [BW-1:0]               b_waddr;
    logic [CW-1:0]               len_clamped;
    logic signed [EXT_BITS-1:0]  acc_ext;

    // Range checks and flat store addresses for write items
    assign row_ok_a = CMP_BITS'(i_cmd.row) < CMP_BITS'(MAX_ROWS);
    assign col_ok_a = CMP_BITS'(i_cmd.col) < CMP_BITS'(MAX_INNER);
    assign row_ok_b = CMP_BITS'(i_cmd.row) < CMP_BITS'(MAX_INNER);
    assign col_ok_b = CMP_BITS'(i_cmd.col) < CMP_BITS'(MAX_COLS);
    assign a_waddr  = AW'(i_cmd.row) * AW'(MAX_INNER) + AW'(i_cmd.col);
    assign b_waddr  = BW'(i_cmd.row) * BW'(MAX_COLS) + BW'(i_cmd.col);

    // Clamp the inner length to the store depth
    assign len_clamped = (CMP_BITS'(i_cmd.len) > CMP_BITS'(MAX_INNER))
                       ? CW'(MAX_INNER) : CW'(i_cmd.len);

    // A store: write from items, read at the walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_a && row_ok_a && col_ok_a) begin
            r_mem_a[a_waddr] <= i_cmd.word;
        end
        r_a_q <= r_mem_a[r_a_addr];
    end

    // B store: write from items, read at the walk address
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_b && row_ok_b && col_ok_b) begin
            r_mem_b[b_waddr] <= i_cmd.word;
        end
        r_b_q <= r_mem_b[r_b_addr];
    end

    // Sequencer: issue reads, then drain the product pipe
    always_comb begin
        n_state  = r_state;
        n_a_addr = r_a_addr;
        n_b_addr = r_b_addr;
        n_left   = r_left;
        n_zero   = r_zero;
        n_v1     = 1'b0;
        n_acc    = r_acc;
        if (r_v2) begin
            n_acc = r_acc + ACC_BITS'(r_prod);
        end
        case (r_state)
            ST_IDLE: begin
                if (i_cmd.start) begin
                    n_a_addr = AW'(i_cmd.row) * AW'(MAX_INNER);
                    n_b_addr = BW'(i_cmd.col);
                    n_left   = len_clamped;
                    n_zero   = !(CMP_BITS'(i_cmd.row) < CMP_BITS'(MAX_ROWS))
                            || !col_ok_b;
                    n_acc    = '0;
                    n_state  = (len_clamped == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                n_v1     = 1'b1;
                n_a_addr = r_a_addr + AW'(1);
                n_b_addr = r_b_addr + BW'(MAX_COLS);
                n_left   = r_left - CW'(1);
                if (r_left == CW'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_v1 && !r_v2) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= n_v1;
            r_v2    <= r_v1;
        end
    end

    // Hold walk addresses, product and accumulator
    always_ff @(posedge i_clk) begin
        r_a_addr <= n_a_addr;
        r_b_addr <= n_b_addr;
        r_left   <= n_left;
        r_zero   <= n_zero;
        r_acc    <= n_acc;
        r_prod   <= word_product(r_a_q, r_b_q, i_cmd.mode);
    end

    // Sign-extend or cut the wrapped accumulator to the result width
    assign acc_ext = EXT_BITS'(r_acc);

    assign o_rsp.busy  = (r_state != ST_IDLE);
    assign o_rsp.valid = (r_state == ST_DONE);
    assign o_rsp.sum   = r_zero ? '0 : acc_ext[SUM_BITS-1:0];

endmodule

/* src/packed_lowbit_matrix_multiply_top.sv */
// ---------------------------------------------------------------------------
// Packed low-bit matrix multiply top level
// Write items fill the A and B word stores; a compute item returns the dot
// product of an A row and a B column over the configured inner length.
// A compute item holds the input until its result is moved on: the walk reads
// one word pair per cycle from the store ports, then a three-stage
// read/product/accumulate pipe drains. The result moves into the output
// register once that register is free.
// Reset clears control state and sets mode to byte, inner length to 64;
// store contents are undefined until written.
// ---------------------------------------------------------------------------
module packed_lowbit_matrix_multiply_top #(
    parameter int MAX_ROWS  = plmm_pkg::MaxRowsDefault,
    parameter int MAX_INNER = plmm_pkg::MaxInnerDefault,
    parameter int MAX_COLS  = plmm_pkg::MaxColsDefault,
    parameter int ACC_BITS  = plmm_pkg::AccBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plmm_in_if.sink     i_in,
    plmm_out_if.source  o_out,
    plmm_cfg_if.sink    i_cfg
);
    import plmm_pkg::*;

    logic [MODE_BITS-1:0]       r_mode;
    logic [LEN_BITS-1:0]        r_inner_len;
    logic                       r_out_valid;
    logic signed [SUM_BITS-1:0] r_out_sum;

    t_eng_cmd eng_cmd;
    t_eng_rsp eng_rsp;
    logic     in_acc;
    logic     take;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BYTE;
            r_inner_len <= LEN_BITS'(64);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MODE:      r_mode      <= i_cfg.data[MODE_BITS-1:0];
                CFG_INNER_LEN: r_inner_len <= i_cfg.data[LEN_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Decode accepted items into engine commands
    assign i_in.ready = !eng_rsp.busy;
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        eng_cmd.wr_a  = 1'b0;
        eng_cmd.wr_b  = 1'b0;
        eng_cmd.start = 1'b0;
        eng_cmd.row   = i_in.row;
        eng_cmd.col   = i_in.col;
        eng_cmd.word  = i_in.word;
        eng_cmd.mode  = r_mode;
        eng_cmd.len   = r_inner_len;
        if (in_acc) begin
            case (i_in.kind)
                KIND_WR_A:    eng_cmd.wr_a  = 1'b1;
                KIND_WR_B:    eng_cmd.wr_b  = 1'b1;
                KIND_COMPUTE: eng_cmd.start = 1'b1;
                default: begin
                end
            endcase
        end
    end

    plmm_engine #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS),
        .ACC_BITS  (ACC_BITS)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (eng_cmd),
        .i_take  (take),
        .o_rsp   (eng_rsp)
    );

    // Move a finished result into the output register when it is free
    assign take = eng_rsp.valid && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_sum <= eng_rsp.sum;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.sum   = r_out_sum;

endmodule

/* sim/packed_lowbit_matrix_multiply_top_tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Packed low-bit matrix multiply testbench
// Loads the A and B word stores through write items, then issues compute items
// under every lane format and a range of inner lengths, zero and oversized
// lengths included. Each returned sum is checked against a predictor that
// keeps its own copy of the stores and registers. Both channels idle in random
// bursts; the result side also holds off once for a long stretch.
// ---------------------------------------------------------------------------
module packed_lowbit_matrix_multiply_top_tb;
    import plmm_pkg::*;

    localparam int STORE_DIM     = MaxInnerDefault;
    localparam int PHASES        = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int SETTLE_CYCLES = 80;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 3000;

    // Codes the package leaves unnamed
    localparam logic [KIND_BITS-1:0] KIND_NONE   = 2'd3;
    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [IDX_BITS-1:0]  row;
        logic [IDX_BITS-1:0]  col;
        logic [WORD_BITS-1:0] word;
    } t_mat_item;

    logic clk;
    logic rst_n;

    plmm_in_if  in_if ();
    plmm_out_if out_if ();
    plmm_cfg_if cfg_if ();

    packed_lowbit_matrix_multiply_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Items waiting for the driver, and sums waiting for the output
    t_mat_item                  pending_items[$];
    logic signed [SUM_BITS-1:0] expected_sums[$];

    // Predictor state: word stores and register copies
    logic [WORD_BITS-1:0] a_mem [STORE_DIM][STORE_DIM];
    logic [WORD_BITS-1:0] b_mem [STORE_DIM][STORE_DIM];
    logic [MODE_BITS-1:0] cfg_mode;
    logic [LEN_BITS-1:0]  cfg_len;

    // Which entries the generated stimulus has filled so far
    bit a_filled [STORE_DIM][STORE_DIM];
    bit b_filled [STORE_DIM][STORE_DIM];

    logic [IDX_BITS-1:0] hot_rows[4];
    logic [IDX_BITS-1:0] hot_cols[4];

    int n_queued;
    int n_accepted;
    int n_sums;
    int mismatches;
    int quiet;
    int src_gap;
    int sink_gap;
    int hold_left;
    bit hold_taken;
    bit long_hold_req;
    bit idle_on;
    bit in_took;

    wire in_fire  = in_if.valid && in_if.ready;
    wire out_fire = out_if.valid && out_if.ready;
    wire cfg_fire = cfg_if.valid && cfg_if.ready;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sum of lane products of one A word and one B word
    function automatic int lane_dot(
        input logic [WORD_BITS-1:0] aw,
        input logic [WORD_BITS-1:0] bw,
        input logic [MODE_BITS-1:0] md
    );
        int total;
        int j;
        int av;
        int bv;
        total = 0;
        case (md)
            MODE_BYTE: begin
                total = int'($signed(aw)) * int'($signed(bw));
            end
            MODE_TERN: begin
                // A code +1 adds, -1 subtracts, 0 and -2 skip
                for (j = 0; j < WORD_BITS / 2; j++) begin
                    av = int'($signed(aw[2*j +: 2]));
                    bv = int'($signed(bw[2*j +: 2]));
                    if (av == 1) begin
                        total += bv;
                    end else if (av == -1) begin
                        total -= bv;
                    end
                end
            end
            default: begin
                // Quad lanes; the unused code lands here too
                for (j = 0; j < WORD_BITS / 4; j++) begin
                    av = int'($signed(aw[4*j +: 4]));
                    bv = int'($signed(bw[4*j +: 4]));
                    total += av * bv;
                end
            end
        endcase
        return total;
    endfunction

    // Wrapped dot product of A row r and B column c
    function automatic logic signed [SUM_BITS-1:0] dot_product(
        input logic [IDX_BITS-1:0] r,
        input logic [IDX_BITS-1:0] c
    );
        logic signed [SUM_BITS-1:0] acc;
        int n;
        int k;
        acc = '0;
        n = (cfg_len > STORE_DIM) ? STORE_DIM : cfg_len;
        for (k = 0; k < n; k++) begin
            acc = acc + lane_dot(a_mem[r][k], b_mem[k][c], cfg_mode);
        end
        return acc;
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_word();
        logic [WORD_BITS-1:0] corner[8];
        corner = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'h88, 8'h77, 8'h55, 8'haa};
        if ($urandom_range(0, 3) == 0) begin
            return corner[$urandom_range(0, 7)];
        end
        return WORD_BITS'($urandom_range(0, 255));
    endfunction

    task automatic push_item(
        input logic [KIND_BITS-1:0] kind,
        input logic [IDX_BITS-1:0]  row,
        input logic [IDX_BITS-1:0]  col,
        input logic [WORD_BITS-1:0] word
    );
        t_mat_item it;
        it.kind = kind;
        it.row  = row;
        it.col  = col;
        it.word = word;
        if (kind == KIND_WR_A) begin
            a_filled[row][col] = 1'b1;
        end else if (kind == KIND_WR_B) begin
            b_filled[row][col] = 1'b1;
        end
        pending_items.insert(pending_items.size(), it);
        n_queued++;
    endtask

    // Wait until the block has taken everything and answered it all
    task automatic settle();
        wait (n_accepted == n_queued);
        wait (expected_sums.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly write-then-compute sequences on filled rows and columns, plus
    // stray overwrites and unknown-kind noise
    task automatic fill_phase(input int quota, input int len, input bit pause_mid);
        int made;
        int pick;
        int n;
        int k;
        bit paused;
        logic [IDX_BITS-1:0] r;
        logic [IDX_BITS-1:0] c;
        made   = 0;
        paused = 1'b0;
        n      = (len > STORE_DIM) ? STORE_DIM : len;
        while (made < quota) begin
            if (pause_mid && !paused && made >= quota / 2) begin
                settle();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                if (n > 16) begin
                    r = hot_rows[$urandom_range(0, 1)];
                    c = hot_cols[$urandom_range(0, 1)];
                end else if ($urandom_range(0, 2) != 0) begin
                    r = hot_rows[$urandom_range(0, 3)];
                    c = hot_cols[$urandom_range(0, 3)];
                end else begin
                    r = IDX_BITS'($urandom_range(0, 63));
                    c = IDX_BITS'($urandom_range(0, 63));
                end
                // fill any entry the compute would read before it runs
                for (k = 0; k < n; k++) begin
                    if (!a_filled[r][k]) begin
                        push_item(KIND_WR_A, r, IDX_BITS'(k), pick_word());
                        made++;
                    end
                    if (!b_filled[k][c]) begin
                        push_item(KIND_WR_B, IDX_BITS'(k), c, pick_word());
                        made++;
                    end
                end
                push_item(KIND_COMPUTE, r, c, WORD_BITS'($urandom_range(0, 255)));
                made++;
            end else if (pick < 90) begin
                r = $urandom_range(0, 1) ? hot_rows[$urandom_range(0, 3)]
                                         : IDX_BITS'($urandom_range(0, 63));
                c = $urandom_range(0, 1) ? hot_cols[$urandom_range(0, 3)]
                                         : IDX_BITS'($urandom_range(0, 63));
                if ($urandom_range(0, 1) != 0) begin
                    push_item(KIND_WR_A, r, IDX_BITS'($urandom_range(0, 63)), pick_word());
                end else begin
                    push_item(KIND_WR_B, IDX_BITS'($urandom_range(0, 63)), c, pick_word());
                end
                made++;
            end else begin
                push_item(KIND_NONE, IDX_BITS'($urandom_range(0, 63)),
                          IDX_BITS'($urandom_range(0, 63)), WORD_BITS'($urandom_range(0, 255)));
                made++;
            end
        end
    endtask

    // Input driver: hold an offered item until taken, then advance
    always @(negedge clk) begin
        t_mat_item it;
        if (!rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (src_gap > 0) begin
                src_gap--;
                in_if.valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
                in_if.valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                src_gap = $urandom_range(1, 8) - 1;
                in_if.valid <= 1'b0;
            end else begin
                it = pending_items.pop_front();
                in_if.valid <= 1'b1;
                in_if.kind  <= it.kind;
                in_if.row   <= it.row;
                in_if.col   <= it.col;
                in_if.word  <= it.word;
            end
        end
    end

    // Result side: random stalls plus one long hold-off
    always @(negedge clk) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (long_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                out_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                sink_gap = $urandom_range(1, 8) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Monitor: track register and store writes, predict and check sums
    always @(posedge clk) begin
        logic signed [SUM_BITS-1:0] want;
        in_took <= in_fire;
        if (cfg_fire) begin
            if (cfg_if.index == CFG_MODE) begin
                cfg_mode = cfg_if.data[MODE_BITS-1:0];
            end else begin
                cfg_len = cfg_if.data[LEN_BITS-1:0];
            end
        end
        if (out_fire) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected sum, expected none, actual %0d", $time, out_if.sum);
                mismatches++;
            end else begin
                want = expected_sums.pop_front();
                n_sums++;
                if (out_if.sum !== want) begin
                    $display("%0t: sum mismatch, expected %0d, actual %0d",
                             $time, want, out_if.sum);
                    mismatches++;
                end
            end
        end
        if (in_fire) begin
            n_accepted++;
            case (in_if.kind)
                KIND_WR_A:    a_mem[in_if.row][in_if.col] = in_if.word;
                KIND_WR_B:    b_mem[in_if.row][in_if.col] = in_if.word;
                KIND_COMPUTE: expected_sums.insert(expected_sums.size(),
                                                   dot_product(in_if.row, in_if.col));
                default: ;
            endcase
        end
    end

    // Watchdog: drop the run when nothing moves for too long
    always @(posedge clk) begin
        if (in_fire || out_fire || cfg_fire) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d sums outstanding",
                     $time, quiet, expected_sums.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [MODE_BITS-1:0] ph_mode[PHASES];
        int                   ph_len[PHASES];
        int                   p;
        ph_mode = '{MODE_BYTE, MODE_TERN, MODE_QUAD, MODE_UNUSED, MODE_BYTE, MODE_TERN,
                    MODE_BYTE, MODE_QUAD, MODE_TERN, MODE_UNUSED, MODE_QUAD, MODE_BYTE};
        ph_len  = '{4, 8, 1, 5, 0, 64, 127, 64, 2, 33, 16, 6};

        clk           = 1'b0;
        rst_n         = 1'b0;
        in_if.valid   = 1'b0;
        in_if.kind    = '0;
        in_if.row     = '0;
        in_if.col     = '0;
        in_if.word    = '0;
        out_if.ready  = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = CFG_MODE;
        cfg_if.data   = '0;
        cfg_mode      = MODE_BYTE;
        cfg_len       = LEN_BITS'(STORE_DIM);
        n_queued      = 0;
        n_accepted    = 0;
        n_sums        = 0;
        mismatches    = 0;
        quiet         = 0;
        src_gap       = 0;
        sink_gap      = 0;
        hold_left     = 0;
        hold_taken    = 1'b0;
        long_hold_req = 1'b0;
        idle_on       = 1'b1;
        in_took       = 1'b0;
        foreach (a_mem[i, j]) begin
            a_mem[i][j]    = '0;
            b_mem[i][j]    = '0;
            a_filled[i][j] = 1'b0;
            b_filled[i][j] = 1'b0;
        end
        hot_rows = '{0, 63, IDX_BITS'($urandom_range(1, 62)), IDX_BITS'($urandom_range(1, 62))};
        hot_cols = '{63, 0, IDX_BITS'($urandom_range(1, 62)), IDX_BITS'($urandom_range(1, 62))};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extreme words and corner indexes at inner length two
        cfg_write(CFG_INNER_LEN, 2);
        push_item(KIND_WR_A, 0, 0, 8'h80);
        push_item(KIND_WR_A, 0, 1, 8'h7f);
        push_item(KIND_WR_B, 0, 0, 8'h80);
        push_item(KIND_WR_B, 1, 0, 8'h81);
        push_item(KIND_COMPUTE, 0, 0, 8'h00);
        push_item(KIND_WR_A, 63, 0, 8'hff);
        push_item(KIND_WR_A, 63, 1, 8'h01);
        push_item(KIND_WR_B, 0, 63, 8'h7f);
        push_item(KIND_WR_B, 1, 63, 8'hff);
        push_item(KIND_COMPUTE, 63, 63, 8'hff);
        push_item(KIND_COMPUTE, 0, 63, 8'h00);
        push_item(KIND_COMPUTE, 63, 0, 8'hff);
        push_item(KIND_NONE, 63, 63, 8'hff);
        push_item(KIND_WR_A, 0, 63, 8'haa);
        push_item(KIND_WR_B, 63, 0, 8'h55);

        // Random phases, each under its own register setting
        for (p = 0; p < PHASES; p++) begin
            settle();
            if (p == PHASES - 1) begin
                idle_on = 1'b0;
            end
            cfg_write(CFG_MODE, CFG_DATA_BITS'(ph_mode[p]));
            cfg_write(CFG_INNER_LEN, CFG_DATA_BITS'(ph_len[p]));
            if (p == 1) begin
                long_hold_req = 1'b1;
            end
            fill_phase(PHASE_ITEMS, ph_len[p], p == 5);
        end
        settle();

        $display("Covered %0d items and %0d checked sums in byte, ternary, quad and unused-code",
                 n_accepted, n_sums);
        $display("modes, inner lengths from 0 to 127, with random stalls and one long hold-off.");
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
